>>> hdl/keyed_failure_burst_detector_macros.svh
// Assertion macros shared by the detector RTL.
`ifndef KEYED_FAILURE_BURST_DETECTOR_MACROS_SVH
`define KEYED_FAILURE_BURST_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KFBD_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("kfbd assertion failed");

// Next-cycle implication, checked outside reset.
`define KFBD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("kfbd assertion failed");

`endif

>>> hdl/kfbd_pkg.sv
`timescale 1ns / 1ps
package kfbd_pkg;

  // Default number of table entries.
  localparam int KFBD_DEPTH = 64;

  // Microseconds per second.
  localparam logic [19:0] US_PER_SEC = 20'd1000000;
  // Width of a scaled window or cooldown in microseconds.
  localparam int TUS_W = 36;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WINDOW    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_COOLDOWN  = 2'd2;

  // Reset values of the registers.
  localparam logic [15:0] WINDOW_RST    = 16'd60;
  localparam logic [7:0]  THRESHOLD_RST = 8'd5;
  localparam logic [15:0] COOLDOWN_RST  = 16'd60;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_UPD
  } kfbd_state_t;

  // One table entry as held by a cell.
  typedef struct packed {
    logic [63:0] key;
    logic        is_local;
    logic [1:0]  service;
    logic [63:0] target;
    logic [7:0]  count;
    logic [63:0] window_start;
    logic [63:0] last_attempt;
    logic [63:0] last_alert;
  } kfbd_entry_t;

  // Search record handed from cell to cell.
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [7:0]  count;
    logic [63:0] window_start;
    logic [63:0] last_alert;
    logic [63:0] oldest_time;
  } kfbd_scan_t;

endpackage

>>> hdl/kfbd_cell.sv
`timescale 1ns / 1ps
module kfbd_cell #(
  parameter int TABLE_DEPTH = kfbd_pkg::KFBD_DEPTH,
  parameter int CELL_IDX    = 0,
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int UW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [UW-1:0]         used,
  input  logic [63:0]           q_key,
  input  logic                  q_local,
  input  kfbd_pkg::kfbd_scan_t  rec_in,
  input  logic [IW-1:0]         hit_idx_in,
  input  logic [IW-1:0]         old_idx_in,
  output kfbd_pkg::kfbd_scan_t  rec_out,
  output logic [IW-1:0]         hit_idx_out,
  output logic [IW-1:0]         old_idx_out,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_idx,
  input  kfbd_pkg::kfbd_entry_t wr_data
);
  import kfbd_pkg::*;

  kfbd_entry_t entry_r;
  kfbd_scan_t  rec_r, rec_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt, old_idx_r, old_idx_nxt;
  logic occupied, match, older;

  // Entry storage, written when the update addresses this cell.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IW'(CELL_IDX))) begin
      entry_r <= wr_data;
    end
  end

  // Merge this entry into the passing search record.
  always_comb begin
    occupied    = UW'(CELL_IDX) < used;
    match       = occupied && !rec_in.found && (entry_r.key == q_key) &&
                  (entry_r.is_local == q_local);
    older       = entry_r.last_attempt < rec_in.oldest_time;
    rec_nxt     = rec_in;
    hit_idx_nxt = hit_idx_in;
    old_idx_nxt = old_idx_in;
    if (match) begin
      rec_nxt.found        = 1'b1;
      rec_nxt.count        = entry_r.count;
      rec_nxt.window_start = entry_r.window_start;
      rec_nxt.last_alert   = entry_r.last_alert;
      hit_idx_nxt          = IW'(CELL_IDX);
    end
    if (older) begin
      rec_nxt.oldest_time = entry_r.last_attempt;
      old_idx_nxt         = IW'(CELL_IDX);
    end
  end

  // Hand the record to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.valid <= 1'b0;
    end else begin
      rec_r.valid <= rec_nxt.valid;
    end
    rec_r.found        <= rec_nxt.found;
    rec_r.count        <= rec_nxt.count;
    rec_r.window_start <= rec_nxt.window_start;
    rec_r.last_alert   <= rec_nxt.last_alert;
    rec_r.oldest_time  <= rec_nxt.oldest_time;
    hit_idx_r          <= hit_idx_nxt;
    old_idx_r          <= old_idx_nxt;
  end

  assign rec_out     = rec_r;
  assign hit_idx_out = hit_idx_r;
  assign old_idx_out = old_idx_r;

endmodule

>>> hdl/keyed_failure_burst_detector.sv
`timescale 1ns / 1ps
// Failed-login burst detector over a table of per-key counters held in a row
// of cells, one entry per cell. After acceptance, a tracked event's lookup and
// oldest-entry search travel along the cell row one cell per cycle, then an
// evaluation state checks the window and cooldown and an update state writes
// the entry and loads the result, waiting while an unaccepted result is held.
// An event that forms no key gives an all-zero result without a search.
// One event is in work at a time; a finished result waits in the output
// register while the next event is taken.
module keyed_failure_burst_detector #(
  parameter int TABLE_DEPTH = kfbd_pkg::KFBD_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // source_address_id[63:0], actor_id[127:64], target_user_id[191:128],
  // event_time_us[255:192]
  input  logic [255:0] in_tdata,
  // has_source_address[0], has_actor[1], service_code[3:2]
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tracked[0], alert[1], notify_ok[2], key_id[66:3], attempts[74:67],
  // alert_service[76:75], alert_target[140:77], new_entry[141], evicted[142],
  // zero[143]
  output logic [143:0] out_tdata,
  // key_is_local[0]
  output logic [0:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import kfbd_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = $clog2(TABLE_DEPTH + 1);

  // Configuration registers.
  logic [15:0] window_r, cooldown_r;
  logic [7:0]  threshold_r;
  logic [TUS_W-1:0] window_us_r, cool_us_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_RST;
      threshold_r <= THRESHOLD_RST;
      cooldown_r  <= COOLDOWN_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_WINDOW:    window_r    <= cfg_pwdata[15:0];
        REG_THRESHOLD: threshold_r <= cfg_pwdata[7:0];
        REG_COOLDOWN:  cooldown_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_WINDOW:    cfg_prdata = {16'd0, window_r};
      REG_THRESHOLD: cfg_prdata = {24'd0, threshold_r};
      REG_COOLDOWN:  cfg_prdata = {16'd0, cooldown_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // Scaled limits in microseconds, registered from the configuration registers.
  always_ff @(posedge clk) begin
    window_us_r <= TUS_W'(window_r) * TUS_W'(US_PER_SEC);
    cool_us_r   <= TUS_W'(cooldown_r) * TUS_W'(US_PER_SEC);
  end

  // Request capture and key formation.
  kfbd_state_t state_r, state_nxt;
  logic        in_acc, key_ok, key_local;
  logic [63:0] key_sel;
  logic [63:0] q_key_r, q_target_r, q_time_r;
  logic        q_local_r, q_tracked_r;
  logic [1:0]  q_svc_r;
  logic        launch_r;
  logic [UW-1:0] used_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    key_ok    = 1'b1;
    key_local = 1'b0;
    key_sel   = in_tdata[63:0];
    if (!in_tuser[0]) begin
      key_local = 1'b1;
      key_sel   = in_tdata[127:64];
      key_ok    = in_tuser[1] && ((in_tuser[3:2] == 2'd1) || (in_tuser[3:2] == 2'd2));
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_key_r     <= key_sel;
      q_local_r   <= key_local;
      q_tracked_r <= key_ok;
      q_svc_r     <= in_tuser[3:2];
      q_target_r  <= in_tdata[191:128];
      q_time_r    <= in_tdata[255:192];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r <= 1'b0;
    end else begin
      launch_r <= in_acc && key_ok;
    end
  end

  // Cell row.
  kfbd_scan_t    rec_w [0:TABLE_DEPTH];
  logic [IW-1:0] hidx_w [0:TABLE_DEPTH];
  logic [IW-1:0] oidx_w [0:TABLE_DEPTH];
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  kfbd_entry_t   wr_data;

  always_comb begin
    rec_w[0].valid        = launch_r;
    rec_w[0].found        = 1'b0;
    rec_w[0].count        = 8'd0;
    rec_w[0].window_start = 64'd0;
    rec_w[0].last_alert   = 64'd0;
    rec_w[0].oldest_time  = '1;
    hidx_w[0]             = '0;
    oidx_w[0]             = '0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    kfbd_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_IDX    (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .used        (used_r),
      .q_key       (q_key_r),
      .q_local     (q_local_r),
      .rec_in      (rec_w[g]),
      .hit_idx_in  (hidx_w[g]),
      .old_idx_in  (oidx_w[g]),
      .rec_out     (rec_w[g+1]),
      .hit_idx_out (hidx_w[g+1]),
      .old_idx_out (oidx_w[g+1]),
      .wr_en       (wr_en),
      .wr_idx      (wr_idx),
      .wr_data     (wr_data)
    );
  end

  // Search outcome and evaluation registers.
  kfbd_scan_t    fr_r;
  logic [IW-1:0] hidx_r, oidx_r;
  logic          expired_r, cool_ok_r, la_zero_r;
  logic          scan_done;

  assign scan_done = rec_w[TABLE_DEPTH].valid;

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN && scan_done) begin
      fr_r   <= rec_w[TABLE_DEPTH];
      hidx_r <= hidx_w[TABLE_DEPTH];
      oidx_r <= oidx_w[TABLE_DEPTH];
    end
    if (state_r == ST_EVAL) begin
      expired_r <= (q_time_r - fr_r.window_start) > 64'(window_us_r);
      cool_ok_r <= (q_time_r - fr_r.last_alert) >= 64'(cool_us_r);
      la_zero_r <= (fr_r.last_alert == 64'd0);
    end
  end

  // Entry update and result formation.
  logic        out_valid_r, load;
  logic [143:0] out_data_r, out_data_nxt;
  logic         out_local_r;
  logic [7:0]   cnt1;
  logic [63:0]  ws1;
  logic         alert, notify, is_new, is_evict;

  assign load = (state_r == ST_UPD) && (!out_valid_r || out_tready);

  always_comb begin
    cnt1     = fr_r.count;
    ws1      = fr_r.window_start;
    if (expired_r) begin
      cnt1 = 8'd1;
      ws1  = q_time_r;
    end else if (fr_r.count < COUNT_MAX) begin
      cnt1 = fr_r.count + 8'd1;
    end
    alert    = fr_r.found && (cnt1 >= threshold_r);
    notify   = (cooldown_r == 16'd0) || la_zero_r || cool_ok_r;
    is_new   = !fr_r.found && (used_r < UW'(TABLE_DEPTH));
    is_evict = !fr_r.found && !is_new;

    wr_en                = load && q_tracked_r;
    wr_idx               = fr_r.found ? hidx_r : (is_new ? used_r[IW-1:0] : oidx_r);
    wr_data.key          = q_key_r;
    wr_data.is_local     = q_local_r;
    wr_data.service      = q_svc_r;
    wr_data.target       = q_target_r;
    wr_data.last_attempt = q_time_r;
    if (fr_r.found) begin
      wr_data.count        = alert ? 8'd0 : cnt1;
      wr_data.window_start = alert ? q_time_r : ws1;
      wr_data.last_alert   = (alert && notify) ? q_time_r : fr_r.last_alert;
    end else begin
      wr_data.count        = 8'd1;
      wr_data.window_start = q_time_r;
      wr_data.last_alert   = 64'd0;
    end

    out_data_nxt = '0;
    if (q_tracked_r) begin
      out_data_nxt[0]       = 1'b1;
      out_data_nxt[1]       = alert;
      out_data_nxt[2]       = alert && notify;
      out_data_nxt[66:3]    = q_key_r;
      out_data_nxt[74:67]   = alert ? cnt1 : 8'd0;
      out_data_nxt[76:75]   = q_svc_r;
      out_data_nxt[140:77]  = q_target_r;
      out_data_nxt[141]     = is_new;
      out_data_nxt[142]     = is_evict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wr_en && is_new) begin
        used_r <= used_r + UW'(1);
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load) begin
      out_data_r  <= out_data_nxt;
      out_local_r <= q_tracked_r && q_local_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_local_r;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = key_ok ? ST_SCAN : ST_UPD;
      ST_SCAN: if (scan_done) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_UPD;
      ST_UPD:  if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

`include "keyed_failure_burst_detector_macros.svh"

  `KFBD_ASSERT_NOW(a_used_bound, 1'b1, used_r <= UW'(TABLE_DEPTH))
  `KFBD_ASSERT_NOW(a_new_evict_excl, out_valid_r, !(out_data_r[141] && out_data_r[142]))
  `KFBD_ASSERT_NOW(a_alert_hit, out_valid_r && out_data_r[1],
                   out_data_r[0] && !out_data_r[141] && !out_data_r[142])
  `KFBD_ASSERT_NEXT(a_scan_to_eval, state_r == ST_SCAN && scan_done, state_r == ST_EVAL)
  `KFBD_ASSERT_NEXT(a_load_from_upd, load, out_valid_r && state_r == ST_IDLE)

endmodule
